/* sv/i2cee_pkg.sv */
// Shared types and constants for the I2C EEPROM transfer sequencer.
// Holds the event and command codes, the one-hot phase type and the item structs.
// No dependencies; every other file of the block imports this package.
package i2cee_pkg;

	localparam int OP_W     = 2;
	localparam int OFFS_W   = 11;
	localparam int CNT_W    = 9;
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 7;
	localparam int CMD_W    = 4;
	localparam int PHASE_W  = 10;

	localparam logic [ADDR_W-1:0] DEV_ADDR_RST = ADDR_W'(80);

	// Event codes on the request channel.
	localparam logic [OP_W-1:0] OP_START_WR = 2'd0;
	localparam logic [OP_W-1:0] OP_START_RD = 2'd1;
	localparam logic [OP_W-1:0] OP_DONE     = 2'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE        = 4'd0,
		CMD_SEND_SINGLE = 4'd1,
		CMD_SEND_START  = 4'd2,
		CMD_SEND_CONT   = 4'd3,
		CMD_SEND_FINISH = 4'd4,
		CMD_RECV_SINGLE = 4'd5,
		CMD_RECV_START  = 4'd6,
		CMD_RECV_CONT   = 4'd7,
		CMD_RECV_FINISH = 4'd8
	} cmd_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE        = 10'b00_0000_0001,
		PH_WRITE_NEXT  = 10'b00_0000_0010,
		PH_WRITE_FINAL = 10'b00_0000_0100,
		PH_SEND_ACK    = 10'b00_0000_1000,
		PH_WAIT_ACK    = 10'b00_0001_0000,
		PH_READ_ONE    = 10'b00_0010_0000,
		PH_READ_FIRST  = 10'b00_0100_0000,
		PH_READ_NEXT   = 10'b00_1000_0000,
		PH_READ_FINAL  = 10'b01_0000_0000,
		PH_READ_WAIT   = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [OFFS_W-1:0] offset;
		logic [CNT_W-1:0]  count;
		logic [BYTE_W-1:0] tx_byte;
		logic [BYTE_W-1:0] rx_byte;
		logic              bus_error;
	} req_t;

	typedef struct packed {
		cmd_t              command;
		logic              set_address;
		logic [ADDR_W-1:0] slave_address;
		logic              read_not_write;
		logic              put_data;
		logic [BYTE_W-1:0] tx_data;
		logic              take_tx;
		logic              rx_valid;
		logic [BYTE_W-1:0] rx_data;
		logic              busy_res;
	} rsp_t;

endpackage

/* sv/i2cee_if.sv */
// Channel interfaces of the I2C EEPROM transfer sequencer: request, response
// and configuration write, each with valid/ready and its payload.
// Depends on i2cee_pkg for the field widths.
interface i2cee_req_if import i2cee_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [OFFS_W-1:0] offset;
	logic [CNT_W-1:0]  count;
	logic [BYTE_W-1:0] tx_byte;
	logic [BYTE_W-1:0] rx_byte;
	logic              bus_error;

	modport source (output valid, op, offset, count, tx_byte, rx_byte, bus_error,
		input ready);
	modport sink (input valid, op, offset, count, tx_byte, rx_byte, bus_error,
		output ready);
endinterface

interface i2cee_rsp_if import i2cee_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic              set_address;
	logic [ADDR_W-1:0] slave_address;
	logic              read_not_write;
	logic              put_data;
	logic [BYTE_W-1:0] tx_data;
	logic              take_tx;
	logic              rx_valid;
	logic [BYTE_W-1:0] rx_data;
	logic              busy_res;

	modport source (output valid, command, set_address, slave_address, read_not_write,
		put_data, tx_data, take_tx, rx_valid, rx_data, busy_res, input ready);
	modport sink (input valid, command, set_address, slave_address, read_not_write,
		put_data, tx_data, take_tx, rx_valid, rx_data, busy_res, output ready);
endinterface

interface i2cee_cfg_if import i2cee_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* sv/i2c_eeprom_transfer_sequencer_core.sv */
// Top level of the I2C EEPROM transfer sequencer. Each request beat (a start
// of a write or read, or a transfer-done event from the I2C master) produces
// exactly one response beat with the command for the master, any slave
// address and data byte to hand over, and any byte read back for the caller.
// The block takes one request per clock while the response side keeps up: a
// request beat is registered, the step logic runs on it against the phase and
// byte counter, and the response lands in an output register.
// The device address register is written through the configuration channel,
// which is always ready, and must only be changed while the sequencer is idle.
// Depends on i2cee_pkg, the channel interfaces and i2cee_step.
module i2c_eeprom_transfer_sequencer_core import i2cee_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	i2cee_cfg_if.sink    cfg,
	i2cee_req_if.sink    req,
	i2cee_rsp_if.source  rsp
);

	logic              valid_s1;
	req_t              item_s1;
	logic              valid_s2;
	rsp_t              res_s2;
	phase_t            phase_q;
	logic [CNT_W-1:0]  left_q;
	logic [ADDR_W-1:0] dev_addr_q;

	phase_t            nxt_phase;
	logic [CNT_W-1:0]  nxt_left;
	rsp_t              res;
	logic              adv;

	// Stage one moves into the response register when that register is free
	// or being emptied in the same cycle.
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
		end else if (cfg.valid) begin
			dev_addr_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.op        <= req.op;
			item_s1.offset    <= req.offset;
			item_s1.count     <= req.count;
			item_s1.tx_byte   <= req.tx_byte;
			item_s1.rx_byte   <= req.rx_byte;
			item_s1.bus_error <= req.bus_error;
		end
	end

	i2cee_step u_step (
		.item      (item_s1),
		.phase     (phase_q),
		.left      (left_q),
		.dev_addr  (dev_addr_q),
		.nxt_phase (nxt_phase),
		.nxt_left  (nxt_left),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			left_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				phase_q <= nxt_phase;
				left_q  <= nxt_left;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.command        = res_s2.command;
	assign rsp.set_address    = res_s2.set_address;
	assign rsp.slave_address  = res_s2.slave_address;
	assign rsp.read_not_write = res_s2.read_not_write;
	assign rsp.put_data       = res_s2.put_data;
	assign rsp.tx_data        = res_s2.tx_data;
	assign rsp.take_tx        = res_s2.take_tx;
	assign rsp.rx_valid       = res_s2.rx_valid;
	assign rsp.rx_data        = res_s2.rx_data;
	assign rsp.busy_res       = res_s2.busy_res;

	// The busy flag of a beat reflects the phase that the same step left behind.
	a_busy_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (res_s2.busy_res == (phase_q != PH_IDLE)))
		else $error("busy flag disagrees with the sequencer phase");

	// A start taken while idle always issues a write-direction address.
	a_start_sets_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && phase_q == PH_IDLE && (item_s1.op == OP_START_WR || item_s1.op == OP_START_RD))
		|=> (res_s2.set_address && !res_s2.read_not_write && res_s2.put_data))
		else $error("start beat did not issue the slave address");

	// Data taken from the request is always handed to the master.
	a_take_implies_put: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.take_tx) |-> res_s2.put_data)
		else $error("tx byte consumed without being sent");

	// A delivered read byte never coincides with an address issue.
	a_rx_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.rx_valid) |-> !res_s2.set_address)
		else $error("read byte delivered on an address step");

endmodule

/* sv/i2cee_step.sv */
// Next-state and command logic of the sequencer for one event beat.
// Purely combinational; the caller holds the phase and byte counter registers.
// Depends on i2cee_pkg.
module i2cee_step import i2cee_pkg::*; (
	input  req_t              item,
	input  phase_t            phase,
	input  logic [CNT_W-1:0]  left,
	input  logic [ADDR_W-1:0] dev_addr,
	output phase_t            nxt_phase,
	output logic [CNT_W-1:0]  nxt_left,
	output rsp_t              res
);

	logic [CNT_W-1:0] left_dec;
	logic [CNT_W-1:0] cnt;

	// The counter saturates at zero; a zero count means one byte.
	assign left_dec = (left != '0) ? left - CNT_W'(1) : left;
	assign cnt      = (item.count != '0) ? item.count : CNT_W'(1);

	always_comb begin
		nxt_phase = phase;
		nxt_left  = left;
		res       = '0;
		res.command = CMD_NONE;
		case (item.op)
			OP_START_WR, OP_START_RD: begin
				if (phase == PH_IDLE) begin
					nxt_left          = cnt;
					res.set_address   = 1'b1;
					res.slave_address = dev_addr | {{(ADDR_W-3){1'b0}}, item.offset[10:8]};
					res.put_data      = 1'b1;
					res.tx_data       = item.offset[BYTE_W-1:0];
					if (item.op == OP_START_WR) begin
						res.command = CMD_SEND_START;
						nxt_phase   = (cnt != CNT_W'(1)) ? PH_WRITE_NEXT : PH_WRITE_FINAL;
					end else begin
						res.command = CMD_SEND_SINGLE;
						nxt_phase   = (cnt == CNT_W'(1)) ? PH_READ_ONE : PH_READ_FIRST;
					end
				end
			end
			OP_DONE: begin
				case (phase)
					PH_WRITE_NEXT: begin
						res.put_data = 1'b1;
						res.tx_data  = item.tx_byte;
						res.take_tx  = 1'b1;
						res.command  = CMD_SEND_CONT;
						nxt_left     = left_dec;
						if (left_dec <= CNT_W'(1)) begin
							nxt_phase = PH_WRITE_FINAL;
						end
					end
					PH_WRITE_FINAL: begin
						res.put_data = 1'b1;
						res.tx_data  = item.tx_byte;
						res.take_tx  = 1'b1;
						res.command  = CMD_SEND_FINISH;
						nxt_left     = left_dec;
						nxt_phase    = PH_SEND_ACK;
					end
					PH_SEND_ACK, PH_WAIT_ACK: begin
						// A poll read that completes cleanly ends the write.
						if (phase == PH_WAIT_ACK && !item.bus_error) begin
							nxt_phase = PH_IDLE;
						end else begin
							res.set_address    = 1'b1;
							res.slave_address  = dev_addr;
							res.read_not_write = 1'b1;
							res.command        = CMD_RECV_SINGLE;
							nxt_phase          = PH_WAIT_ACK;
						end
					end
					PH_READ_ONE: begin
						res.set_address    = 1'b1;
						res.slave_address  = dev_addr;
						res.read_not_write = 1'b1;
						res.command        = CMD_RECV_SINGLE;
						nxt_phase          = PH_READ_WAIT;
					end
					PH_READ_FIRST: begin
						res.set_address    = 1'b1;
						res.slave_address  = dev_addr;
						res.read_not_write = 1'b1;
						res.command        = CMD_RECV_START;
						nxt_phase          = (left <= CNT_W'(2)) ? PH_READ_FINAL : PH_READ_NEXT;
					end
					PH_READ_NEXT: begin
						res.rx_valid = 1'b1;
						res.rx_data  = item.rx_byte;
						res.command  = CMD_RECV_CONT;
						nxt_left     = left_dec;
						if (left_dec <= CNT_W'(2)) begin
							nxt_phase = PH_READ_FINAL;
						end
					end
					PH_READ_FINAL: begin
						res.rx_valid = 1'b1;
						res.rx_data  = item.rx_byte;
						res.command  = CMD_RECV_FINISH;
						nxt_left     = left_dec;
						nxt_phase    = PH_READ_WAIT;
					end
					PH_READ_WAIT: begin
						res.rx_valid = 1'b1;
						res.rx_data  = item.rx_byte;
						nxt_left     = left_dec;
						nxt_phase    = PH_IDLE;
					end
					default: begin
						nxt_phase = PH_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase
		res.busy_res = (nxt_phase != PH_IDLE);
	end

endmodule
